### src/heap_sorter_defines.svh
// Assertion helpers for the heap sorter checker.
`ifndef HEAP_SORTER_DEFINES_SVH
`define HEAP_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define HS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define HS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/hs_pkg.sv
package hs_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROOT_RD,
		ST_ROOT_LD,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_SWAP_RD,
		ST_SWAP_WR,
		ST_EMIT_RD,
		ST_EMIT_PUSH
	} hs_state_t;

	// Which entry wins a sift-down compare
	typedef enum logic [1:0] {
		PICK_NONE,
		PICK_LEFT,
		PICK_RIGHT
	} hs_child_t;

	typedef struct packed {
		hs_child_t          child;
		logic signed [31:0] value;
	} hs_pick_t;

	// Register index of the order control (byte address bit 2)
	localparam logic REG_ORDER = 1'b0;

	// Signed greater-than
	function automatic logic sgt(input logic signed [31:0] a, input logic signed [31:0] b);
		return a > b;
	endfunction

endpackage

### src/hs_store.sv
module hs_store #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [31:0]                wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [31:0]                rdata_a,
	output logic [31:0]                rdata_b
);

	logic [31:0] mem [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### src/hs_pick.sv
module hs_pick (
	input  logic signed [31:0] hold_value,
	input  logic signed [31:0] left_value,
	input  logic signed [31:0] right_value,
	input  logic               right_ok,
	output hs_pkg::hs_pick_t   pick
);
	import hs_pkg::*;

	logic               left_wins;
	logic signed [31:0] best;

	// Parent against left child, then the winner against right child
	always_comb begin
		left_wins = sgt(left_value, hold_value);
		best      = left_wins ? left_value : hold_value;
		if (right_ok && sgt(right_value, best)) begin
			pick.child = PICK_RIGHT;
			pick.value = right_value;
		end else if (left_wins) begin
			pick.child = PICK_LEFT;
			pick.value = left_value;
		end else begin
			pick.child = PICK_NONE;
			pick.value = hold_value;
		end
	end

endmodule

### src/heap_sorter.sv
// Heap sorter. Values load one per cycle while sample_stall is low into a DEPTH-entry
// store; the transaction with final_item set closes the set (values past DEPTH are
// dropped and flagged on every result of the set) and starts an in-place heap sort: a
// bottom-up max-heap build, then root-to-end swaps each followed by a sift-down. All
// work runs through one compare unit and a store with one write and two read ports.
// Each sift-down level reads both children, then compares and writes; the held value
// is written where the sift stops. Each build root is read and loaded first, and each
// extraction reads and swaps root and end. Results then leave in turn, each read and
// then pushed, held while stalled; ascending, or descending when the order register
// was set at the final transaction. sample_stall is high from the final transaction
// until the last result is placed in the output register.
module heap_sorter #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] sample_value,
	input  logic               final_item,
	// Result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] sorted_value,
	output logic               end_of_run,
	output logic               dropped_values,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import hs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 1;

	hs_state_t state_q, state_d;

	logic [CW-1:0]      count_q, n_q, len_q, n_new;
	logic               ovf_q, build_q, desc_q, desc_run_q;
	logic [AW-1:0]      kb_q, cur_q, e_q;
	logic signed [31:0] hold_q;
	logic               full, accept, out_free, last_out, sift_done;
	logic [IW-1:0]      lc, rc;
	logic               lc_ok, rc_ok;
	logic               we;
	logic [AW-1:0]      waddr, raddr_a, raddr_b, emit_addr;
	logic [31:0]        wdata, rdata_a, rdata_b;
	hs_pick_t           pick;

	logic               result_valid_q, end_of_run_q, dropped_q;
	logic signed [31:0] sorted_value_q;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_ORDER) begin
			desc_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_ORDER) ? {31'd0, desc_q} : 32'd0;

	// Handshake and index arithmetic
	assign sample_stall = (state_q != ST_LOAD);
	assign accept       = sample_valid && !sample_stall;
	assign full         = (count_q == CW'(DEPTH));
	assign n_new        = full ? CW'(DEPTH) : count_q + 1'b1;
	assign out_free     = !result_valid_q || !result_stall;
	assign last_out     = (e_q == AW'(n_q - 1'b1));
	assign lc           = {cur_q, 1'b1};
	assign rc           = lc + 1'b1;
	assign lc_ok        = lc < IW'(len_q);
	assign rc_ok        = rc < IW'(len_q);
	assign emit_addr    = desc_run_q ? AW'(n_q - 1'b1 - CW'(e_q)) : e_q;

	hs_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	hs_pick u_pick (
		.hold_value  (hold_q),
		.left_value  (rdata_a),
		.right_value (rdata_b),
		.right_ok    (rc_ok),
		.pick        (pick)
	);

	// Sequencer: next state and store control
	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = cur_q;
		wdata     = hold_q;
		raddr_a   = AW'(lc);
		raddr_b   = AW'(rc);
		sift_done = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					we    = !full;
					waddr = AW'(count_q);
					wdata = sample_value;
					if (final_item) begin
						state_d = (n_new > CW'(1)) ? ST_ROOT_RD : ST_EMIT_RD;
					end
				end
			end
			ST_ROOT_RD: begin
				raddr_a = kb_q - 1'b1;
				state_d = ST_ROOT_LD;
			end
			ST_ROOT_LD: begin
				state_d = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				if (lc_ok) begin
					state_d = ST_SIFT_CMP;
				end else begin
					we        = 1'b1;
					sift_done = 1'b1;
				end
			end
			ST_SIFT_CMP: begin
				we    = 1'b1;
				wdata = pick.value;
				if (pick.child == PICK_NONE) begin
					sift_done = 1'b1;
				end else begin
					state_d = ST_SIFT_RD;
				end
			end
			ST_SWAP_RD: begin
				raddr_a = '0;
				raddr_b = AW'(len_q - 1'b1);
				state_d = ST_SWAP_WR;
			end
			ST_SWAP_WR: begin
				we      = 1'b1;
				waddr   = AW'(len_q - 1'b1);
				wdata   = rdata_a;
				state_d = ST_SIFT_RD;
			end
			ST_EMIT_RD: begin
				raddr_a = emit_addr;
				state_d = ST_EMIT_PUSH;
			end
			ST_EMIT_PUSH: begin
				raddr_a = emit_addr;
				if (out_free) begin
					state_d = last_out ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
		// After a sift: next build root, next extraction, or output
		if (sift_done) begin
			if (build_q && kb_q > AW'(1)) begin
				state_d = ST_ROOT_RD;
			end else if (len_q > CW'(1)) begin
				state_d = ST_SWAP_RD;
			end else begin
				state_d = ST_EMIT_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (state_q == ST_EMIT_PUSH && out_free && last_out) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// Sort datapath registers
	always_ff @(posedge clk) begin
		if (accept && final_item) begin
			n_q        <= n_new;
			len_q      <= n_new;
			kb_q       <= AW'(n_new >> 1);
			build_q    <= 1'b1;
			desc_run_q <= desc_q;
			e_q        <= '0;
		end
		case (state_q)
			ST_ROOT_LD: begin
				hold_q <= rdata_a;
				cur_q  <= kb_q - 1'b1;
			end
			ST_SIFT_CMP: begin
				case (pick.child)
					PICK_LEFT:  cur_q <= AW'(lc);
					PICK_RIGHT: cur_q <= AW'(rc);
					default:    cur_q <= cur_q;
				endcase
			end
			ST_SWAP_WR: begin
				hold_q <= rdata_b;
				len_q  <= len_q - 1'b1;
				cur_q  <= '0;
			end
			ST_EMIT_PUSH: begin
				if (out_free) begin
					e_q <= e_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (sift_done && build_q) begin
			if (kb_q > AW'(1)) begin
				kb_q <= kb_q - 1'b1;
			end else begin
				build_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_PUSH && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_PUSH && out_free) begin
			sorted_value_q <= rdata_a;
			end_of_run_q   <= last_out;
			dropped_q      <= ovf_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign sorted_value   = sorted_value_q;
	assign end_of_run     = end_of_run_q;
	assign dropped_values = dropped_q;

endmodule

### src/hs_checker.sv
`include "heap_sorter_defines.svh"

module hs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               final_item,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] sorted_value,
	input logic               end_of_run,
	input logic               dropped_values
);

	// A held result keeps its value
	`HS_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(sorted_value), "stalled result changed")

	// Closing transaction starts the sort, so input goes stalled
	`HS_ASSERT_NEXT(a_sort_start, sample_valid && !sample_stall && final_item, sample_stall, "input open after final transaction")

	// No new input while a run is only partly delivered
	`HS_ASSERT_NOW(a_run_closed, result_valid && !end_of_run, sample_stall, "input open mid-run")

	// Drop flag is the same on back-to-back results of one run
	`HS_ASSERT_NEXT(a_drop_flag, result_valid && !result_stall && !end_of_run, !result_valid || dropped_values == $past(dropped_values), "drop flag changed within run")

endmodule

bind heap_sorter hs_checker u_hs_checker (.*);
